// File: sv/nll_pkg.sv
// Package: widths, constants and shared types for the ladder lowpass.
`timescale 1ns / 1ps
package nll_pkg;
  localparam int SampleBits = 24;
  localparam int FracBits = SampleBits - 4;
  localparam int CoefBits = 18;
  localparam int AmtBits = 17;
  localparam int DivBits = 2 * FracBits + 6;
  localparam logic [1:0] RegCutoff = 2'd0;
  localparam logic [1:0] RegDrive = 2'd1;
  localparam logic [1:0] RegReso = 2'd2;
  localparam logic ActFilter = 1'b0;
  localparam logic ActClear = 1'b1;
  typedef logic signed [SampleBits-1:0] sample_t;
endpackage

// File: sv/nll_tanh.sv
// Rational tanh approximation with a bit-serial restoring divider.
`timescale 1ns / 1ps
module nll_tanh (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [nll_pkg::SampleBits+1:0] x,
  output logic done,
  output nll_pkg::sample_t y
);
  localparam int F = nll_pkg::FracBits;
  localparam int W = nll_pkg::SampleBits;
  localparam int D = nll_pkg::DivBits;
  typedef enum logic [1:0] {S_IDLE, S_SQ, S_DIV, S_MUL} st_t;
  st_t st;
  logic neg;
  logic [W-2:0] a;
  logic [D-1:0] num;
  logic [D-1:0] den;
  logic [D:0] rem;
  logic [D-1:0] quo;
  logic [5:0] cnt;
  logic signed [W+1:0] xc;
  logic [2*W-2:0] sq;
  logic [F+4:0] a2;
  logic [D:0] trial;
  logic [W+F+4:0] prod;
  logic [W-2:0] ym;
  localparam logic signed [W+1:0] Lim = (W+2)'(4) <<< F;
  always_comb begin
    if (x > Lim) xc = Lim;
    else if (x < -Lim) xc = -Lim;
    else xc = x;
    sq = (2*W-1)'(a) * (2*W-1)'(a);
    a2 = sq[F+F+4:F];
    trial = {rem[D-1:0], num[D-1]};
    prod = (W+F+5)'(a) * (W+F+5)'(quo[F+4:0]);
    ym = prod[F+W-2:F];
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        S_IDLE: begin
          if (start) begin
            neg <= xc[W+1];
            a <= (W-1)'(xc[W+1] ? -xc : xc);
            st <= S_SQ;
          end
        end
        S_SQ: begin
          num <= D'((D'(27) << F) + D'(a2)) << F;
          den <= (D'(27) << F) + D'(9) * D'(a2);
          rem <= '0;
          quo <= '0;
          cnt <= 6'(D - 1);
          st <= S_DIV;
        end
        S_DIV: begin
          num <= num << 1;
          if (trial >= {1'b0, den}) begin
            rem <= trial - {1'b0, den};
            quo <= {quo[D-2:0], 1'b1};
          end else begin
            rem <= trial;
            quo <= {quo[D-2:0], 1'b0};
          end
          if (cnt == '0) st <= S_MUL;
          else cnt <= cnt - 6'd1;
        end
        S_MUL: begin
          y <= neg ? -W'({1'b0, ym}) : W'({1'b0, ym});
          done <= 1'b1;
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end
  a_done_from_mul: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(st) == S_MUL) else $error("done without multiply");
  a_div_stays: assert property (@(posedge clk) disable iff (rst)
    (st == S_DIV && cnt != '0) |=> st == S_DIV) else $error("divider left early");
  a_mag_bound: assert property (@(posedge clk) disable iff (rst)
    st == S_SQ |-> a <= (W-1)'(Lim)) else $error("clamp failed");
endmodule

// File: sv/nonlinear_ladder_lowpass.sv
// Top level: sequencer around a shared tanh unit and a shared multiplier.
//  channel | signals                      | direction
//  in      | valid ready action sample_in | into block
//  out     | out_valid out_ready sample_out| out of block
//  cfg     | cfg_we cfg_index cfg_data     | into block
// A sample runs six tanh passes through one 46-step bit-serial divider; a
// clear gives no item. Reset clears the stages, drive and resonance and
// sets the cutoff to its default. Ready is low while a sample is in work
// and while a result waits for out_ready.
`timescale 1ns / 1ps
module nonlinear_ladder_lowpass (
  input  logic clk,
  input  logic rst,
  input  logic valid,
  output logic ready,
  input  logic action,
  input  logic signed [nll_pkg::SampleBits-1:0] sample_in,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [nll_pkg::SampleBits-1:0] sample_out,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [nll_pkg::CoefBits-1:0] cfg_data
);
  localparam int W = nll_pkg::SampleBits;
  localparam int PW = W + 2;
  typedef enum logic [2:0] {S_IDLE, S_DRV, S_TIN, S_TW, S_FB, S_POLE, S_OUT}
    st_t;
  st_t st;
  logic [nll_pkg::CoefBits-1:0] g;
  logic [nll_pkg::AmtBits-1:0] drive, reso;
  nll_pkg::sample_t stg [4];
  nll_pkg::sample_t xin;
  logic [2:0] idx;
  logic signed [W+1:0] targ;
  logic [nll_pkg::AmtBits-1:0] k;
  logic tstart;
  logic tdone;
  nll_pkg::sample_t ty;
  logic signed [PW-1:0] ma;
  logic signed [19:0] mb;
  logic signed [PW+19:0] mp;
  logic signed [PW+3:0] ms;
  logic signed [W+3:0] nv;
  nll_pkg::sample_t dsat;
  nll_pkg::sample_t nsat;
  logic [34:0] kp;
  localparam logic signed [W+1:0] SMax = (W+2)'((64'sd1 <<< (W-1)) - 1);
  localparam logic signed [W+1:0] SMin = -(W+2)'(64'sd1 <<< (W-1));
  assign mp = (PW+20)'(ma) * (PW+20)'(mb);
  assign kp = 35'(reso) * 35'(62259);
  assign k = kp[32:16];
  assign ready = (st == S_IDLE) && !out_valid;
  nll_tanh u_tanh (.clk(clk), .rst(rst), .start(tstart), .x(targ),
    .done(tdone), .y(ty));
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (st)
      S_DRV: begin
        ma = PW'(xin);
        mb = 20'(18'h10000) + 20'({drive, 1'b0});
      end
      S_FB: begin
        ma = PW'(stg[3]);
        mb = 20'({1'b0, k});
      end
      S_POLE: begin
        ma = PW'(ty) - PW'(stg[idx[1:0]]);
        mb = 20'({1'b0, g});
      end
      default: ;
    endcase
    ms = (PW+4)'(mp >>> 16);
    nv = (W+4)'(stg[idx[1:0]]) + (W+4)'(ms);
    dsat = (ms > (PW+4)'(SMax)) ? W'(SMax) : (ms < (PW+4)'(SMin)) ? W'(SMin) : W'(ms);
    nsat = (nv > (W+4)'(SMax)) ? W'(SMax) : (nv < (W+4)'(SMin)) ? W'(SMin) : W'(nv);
    tstart = (st == S_TIN);
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      out_valid <= 1'b0;
      g <= 18'd8408;
      drive <= '0;
      reso <= '0;
      for (int i = 0; i < 4; i++) stg[i] <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          nll_pkg::RegCutoff: g <= cfg_data;
          nll_pkg::RegDrive: drive <= cfg_data[nll_pkg::AmtBits-1:0];
          nll_pkg::RegReso: reso <= cfg_data[nll_pkg::AmtBits-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (st)
        S_IDLE: begin
          if (valid && ready) begin
            if (action == nll_pkg::ActClear) begin
              for (int i = 0; i < 4; i++) stg[i] <= '0;
            end else begin
              xin <= sample_in;
              idx <= 3'd4;
              st <= S_DRV;
            end
          end
        end
        S_DRV: begin
          targ <= (W+2)'(dsat);
          st <= S_TIN;
        end
        S_TIN: st <= S_TW;
        S_TW: begin
          if (tdone) begin
            if (idx == 3'd4) st <= S_FB;
            else if (idx == 3'd5) begin
              sample_out <= ty;
              st <= S_OUT;
            end else st <= S_POLE;
          end
        end
        S_FB: begin
          targ <= (W+2)'(ty) - (W+2)'(ms);
          idx <= 3'd0;
          st <= S_TIN;
        end
        S_POLE: begin
          stg[idx[1:0]] <= nsat;
          targ <= (W+2)'(nsat);
          idx <= (idx == 3'd3) ? 3'd5 : idx + 3'd1;
          st <= S_TIN;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (st != S_IDLE) |-> !ready) else $error("ready while busy");
  a_out_once: assert property (@(posedge clk) disable iff (rst)
    (st == S_OUT) |=> out_valid) else $error("result lost");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (st == S_POLE) |-> idx < 3'd4) else $error("bad stage index");
endmodule
